[sv/mhpq_pkg.sv]
// Shared constants, types and helpers for the max-heap priority queue.
// No dependencies.
`default_nettype none

package mhpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 31;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int STAT_W   = 2;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam status_t ST_INSERTED = 2'd0;
  localparam status_t ST_REMOVED  = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  localparam cnt_t CNT_FULL = cnt_t'(CAPACITY);

  // 1-based heap position to RAM address
  function automatic addr_t addr_of(input cnt_t pos);
    cnt_t d;
    d = pos - cnt_t'(1);
    return d[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/mhpq_if.sv]
// Valid/ready channel interfaces for queue requests and responses.
// Depends on mhpq_pkg.
`default_nettype none

interface mhpq_req_if;
  logic              valid;
  logic              ready;
  logic              mode;
  mhpq_pkg::key_t    key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

interface mhpq_rsp_if;
  logic              valid;
  logic              ready;
  mhpq_pkg::status_t status;
  mhpq_pkg::key_t    value;
  mhpq_pkg::cnt_t    occupancy;

  modport source (output valid, output status, output value, output occupancy, input ready);
  modport sink   (input valid, input status, input value, input occupancy, output ready);
endinterface

`default_nettype wire

[sv/max_heap_priority_queue.sv]
// Binary max-heap priority queue: sequencer, compare unit and output register.
// Depends on mhpq_pkg, mhpq_if (mhpq_req_if, mhpq_rsp_if) and mhpq_ram.
//
// Holds up to 1024 31-bit keys in a 1-based heap kept in one RAM, using one
// address per cycle with a registered read. Each request (insert or
// remove-max) yields exactly one response carrying the status, the removed
// key (zero unless a key was removed) and the occupancy afterwards. One
// request is worked at a time; req.ready is high only while idle. An insert
// alternates reading the parent and comparing with a write, climbing one
// level per pair until it reaches the root or stops below a parent; a remove
// reads the top and then the last entry, then at each level it descends it
// checks for children, reads the left child and reads the right child with
// the compare and write, and at the end it finishes through the done state.
// The RAM port, used for one access a cycle, sets this pace. A full insert or
// an empty remove goes straight to the done state without a RAM access. After
// each response the block returns to idle before it accepts the next
// request, and it waits in its last state while an earlier response is still
// held. No clearing pass is needed after reset.
`default_nettype none

module max_heap_priority_queue (
  input  wire logic   clk,
  input  wire logic   rst,
  mhpq_req_if.sink    req,
  mhpq_rsp_if.source  rsp
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS     = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_RM_TOP  = 4'd3;
  localparam logic [3:0] S_RM_LAST = 4'd4;
  localparam logic [3:0] S_RM_CHK  = 4'd5;
  localparam logic [3:0] S_RM_L    = 4'd6;
  localparam logic [3:0] S_RM_R    = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]        state, state_next;
  mhpq_pkg::cnt_t    count, count_next;
  mhpq_pkg::cnt_t    pos, pos_next;
  mhpq_pkg::key_t    key, key_next;
  mhpq_pkg::key_t    top, top_next;
  mhpq_pkg::key_t    cand, cand_next;
  mhpq_pkg::status_t res_status, res_status_next;
  mhpq_pkg::key_t    res_value, res_value_next;

  logic              rsp_valid;
  mhpq_pkg::status_t rsp_status;
  mhpq_pkg::key_t    rsp_value;
  mhpq_pkg::cnt_t    rsp_occ;

  logic              mem_we;
  mhpq_pkg::addr_t   mem_waddr;
  mhpq_pkg::key_t    mem_wdata;
  mhpq_pkg::addr_t   mem_raddr;
  mhpq_pkg::key_t    mem_rdata;

  logic [mhpq_pkg::CNT_W:0] child_l;
  logic [mhpq_pkg::CNT_W:0] count_ext;
  mhpq_pkg::cnt_t           left_pos;
  mhpq_pkg::cnt_t           right_pos;
  mhpq_pkg::key_t           big;
  mhpq_pkg::cnt_t           big_pos;
  logic                     rsp_free;

  assign child_l   = {pos, 1'b0};
  assign count_ext = {1'b0, count};
  assign left_pos  = child_l[mhpq_pkg::CNT_W-1:0];
  assign right_pos = left_pos | mhpq_pkg::cnt_t'(1);
  assign rsp_free  = !rsp_valid || rsp.ready;

  // larger child; left wins a tie
  always_comb begin
    if (cand < mem_rdata) begin
      big     = mem_rdata;
      big_pos = right_pos;
    end else begin
      big     = cand;
      big_pos = left_pos;
    end
  end

  mhpq_ram #(
    .DEPTH (mhpq_pkg::CAPACITY),
    .WIDTH (mhpq_pkg::KEY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.value     = rsp_value;
  assign rsp.occupancy = rsp_occ;

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    key_next        = key;
    top_next        = top;
    cand_next       = cand;
    res_status_next = res_status;
    res_value_next  = res_value;
    mem_we          = 1'b0;
    mem_waddr       = mhpq_pkg::addr_of(pos);
    mem_wdata       = key;
    mem_raddr       = mhpq_pkg::addr_of(pos);
    case (state)
      S_IDLE: begin
        res_value_next = '0;
        if (req.valid) begin
          if (req.mode == mhpq_pkg::MODE_INSERT) begin
            if (count == mhpq_pkg::CNT_FULL) begin
              res_status_next = mhpq_pkg::ST_FULL;
              state_next      = S_DONE;
            end else begin
              pos_next        = count + mhpq_pkg::cnt_t'(1);
              count_next      = count + mhpq_pkg::cnt_t'(1);
              key_next        = req.key;
              res_status_next = mhpq_pkg::ST_INSERTED;
              state_next      = S_INS;
            end
          end else begin
            if (count == '0) begin
              res_status_next = mhpq_pkg::ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              mem_raddr       = mhpq_pkg::addr_of(mhpq_pkg::cnt_t'(1));
              res_status_next = mhpq_pkg::ST_REMOVED;
              state_next      = S_RM_TOP;
            end
          end
        end
      end
      S_INS: begin
        if (pos == mhpq_pkg::cnt_t'(1)) begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          mem_raddr  = mhpq_pkg::addr_of(pos >> 1);
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (key > mem_rdata) begin
          mem_wdata  = mem_rdata;
          pos_next   = pos >> 1;
          state_next = S_INS;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RM_TOP: begin
        top_next   = mem_rdata;
        mem_raddr  = mhpq_pkg::addr_of(count);
        state_next = S_RM_LAST;
      end
      S_RM_LAST: begin
        key_next       = mem_rdata;
        count_next     = count - mhpq_pkg::cnt_t'(1);
        pos_next       = mhpq_pkg::cnt_t'(1);
        res_value_next = top;
        state_next     = S_RM_CHK;
      end
      S_RM_CHK: begin
        if (child_l > count_ext) begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          mem_raddr  = mhpq_pkg::addr_of(left_pos);
          state_next = S_RM_L;
        end
      end
      S_RM_L: begin
        cand_next = mem_rdata;
        if (left_pos < count) begin
          mem_raddr  = mhpq_pkg::addr_of(right_pos);
          state_next = S_RM_R;
        end else begin
          // single child
          mem_we = 1'b1;
          if (key >= mem_rdata) begin
            state_next = S_DONE;
          end else begin
            mem_wdata  = mem_rdata;
            pos_next   = left_pos;
            state_next = S_RM_CHK;
          end
        end
      end
      S_RM_R: begin
        mem_we = 1'b1;
        if (key >= big) begin
          state_next = S_DONE;
        end else begin
          mem_wdata  = big;
          pos_next   = big_pos;
          state_next = S_RM_CHK;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    key        <= key_next;
    top        <= top_next;
    cand       <= cand_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
    if (state == S_DONE && rsp_free) begin
      rsp_status <= res_status;
      rsp_value  <= res_value;
      rsp_occ    <= count;
    end
  end

endmodule

`default_nettype wire

[sv/mhpq_ram.sv]
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
`default_nettype none

module mhpq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 31
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[dv/max_heap_priority_queue_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for max_heap_priority_queue: directed and random
// insert/remove traffic with random idling, checked against a heap predictor.
// Depends on mhpq_pkg, mhpq_if and the max_heap_priority_queue RTL.

module max_heap_priority_queue_tb;
  import mhpq_pkg::*;

  typedef struct packed {
    status_t status;
    key_t    value;
    cnt_t    occupancy;
  } heap_result_t;

  logic clk;
  logic rst;

  mhpq_req_if req_ch ();
  mhpq_rsp_if rsp_ch ();

  max_heap_priority_queue DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  key_t         heap_model [1:CAPACITY];
  int           held_count;
  heap_result_t pending_results [$];
  bit           no_idle;
  int           items_sent;
  int           results_checked;
  int           mismatches;
  int           removes_seen;
  int           empties_seen;
  int           fulls_seen;
  int           ready_hold;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic heap_result_t predict_step(input logic mode, input key_t key);
    heap_result_t r;
    int           pos;
    int           parent;
    int           child;
    key_t         last;
    r = '0;
    if (mode == MODE_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        held_count++;
        pos = held_count;
        while (pos != 1 && key > heap_model[pos / 2]) begin
          heap_model[pos] = heap_model[pos / 2];
          pos = pos / 2;
        end
        heap_model[pos] = key;
        r.status = ST_INSERTED;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.value = heap_model[1];
      last = heap_model[held_count];
      held_count--;
      parent = 1;
      child = 2;
      while (child <= held_count) begin
        if (child < held_count && heap_model[child] < heap_model[child + 1]) child++;
        if (last >= heap_model[child]) break;
        heap_model[parent] = heap_model[child];
        parent = child;
        child = child * 2;
      end
      heap_model[parent] = last;
      r.status = ST_REMOVED;
    end
    r.occupancy = cnt_t'(held_count);
    return r;
  endfunction

  // wide keys, a narrow band that forces ties, and the extremes
  function automatic key_t rand_key();
    case ($urandom_range(0, 3))
      0:       return key_t'($urandom_range(0, 15));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return key_t'($urandom);
    endcase
  endfunction

  task automatic send_request(input logic mode, input key_t key);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= mode;
    req_ch.key   <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(predict_step(mode, key));
    items_sent++;
  endtask

  task automatic send_random(input int n, input int remove_pct);
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_request(($urandom_range(1, 100) <= remove_pct) ? MODE_REMOVE : MODE_INSERT,
                   rand_key());
    end
  endtask

  task automatic test_directed();
    send_request(MODE_REMOVE, key_t'(0));
    send_request(MODE_INSERT, key_t'(0));
    send_request(MODE_REMOVE, '1);
    send_request(MODE_REMOVE, key_t'(0));
    send_request(MODE_INSERT, '1);
    send_request(MODE_INSERT, key_t'(0));
    send_request(MODE_INSERT, key_t'(31'h5555_5555));
    send_request(MODE_INSERT, key_t'(31'h2AAA_AAAA));
    send_request(MODE_INSERT, '1);
    repeat (4) send_request(MODE_INSERT, key_t'(5));
    repeat (9) send_request(MODE_REMOVE, key_t'(0));
    send_request(MODE_REMOVE, key_t'(31'h1234_5678));
  endtask

  task automatic test_mixed();
    send_random(280, 50);
  endtask

  task automatic test_fill_to_full();
    int n;
    n = 0;
    while (held_count < CAPACITY) begin
      if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_request(MODE_INSERT, rand_key());
      n++;
    end
    repeat (3) send_request(MODE_INSERT, rand_key());
    send_request(MODE_INSERT, '1);
    send_request(MODE_REMOVE, rand_key());
    send_request(MODE_INSERT, '1);
    send_request(MODE_INSERT, key_t'(0));
    send_request(MODE_REMOVE, rand_key());
    send_request(MODE_INSERT, key_t'(0));
    send_request(MODE_INSERT, rand_key());
  endtask

  task automatic test_drain();
    send_random(250, 80);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      ready_hold = 0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      results_checked++;
      case (rsp_ch.status)
        ST_REMOVED: removes_seen++;
        ST_EMPTY:   empties_seen++;
        ST_FULL:    fulls_seen++;
        default:    ;
      endcase
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result status=%0d value=%h occupancy=%0d", $time,
                 rsp_ch.status, rsp_ch.value, rsp_ch.occupancy);
      end else begin
        heap_result_t exp_r;
        exp_r = pending_results.pop_front();
        if (rsp_ch.status !== exp_r.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   rsp_ch.status);
        end
        if (rsp_ch.value !== exp_r.value) begin
          mismatches++;
          $display("%0t: value expected %h actual %h", $time, exp_r.value, rsp_ch.value);
        end
        if (rsp_ch.occupancy !== exp_r.occupancy) begin
          mismatches++;
          $display("%0t: occupancy expected %0d actual %0d", $time, exp_r.occupancy,
                   rsp_ch.occupancy);
        end
      end
      ready_hold = no_idle ? 0 : $urandom_range(0, 6);
      if (ready_hold != 0) rsp_ch.ready <= 1'b0;
    end else if (!rsp_ch.ready) begin
      if (ready_hold > 0) ready_hold--;
      if (ready_hold == 0) rsp_ch.ready <= 1'b1;
    end
  end

  initial begin
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.mode  <= MODE_INSERT;
    req_ch.key   <= '0;
    held_count      = 0;
    no_idle         = 1'b0;
    items_sent      = 0;
    results_checked = 0;
    mismatches      = 0;
    removes_seen    = 0;
    empties_seen    = 0;
    fulls_seen      = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_mixed();
    test_fill_to_full();
    test_drain();

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d items, checked %0d results", items_sent, results_checked);
    $display("Removes %0d, empty removes %0d, rejected full inserts %0d", removes_seen,
             empties_seen, fulls_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
